/* sv/plasma_pixel_generator_macros.svh */
// ----------------------------------------------------------------------------
// Plasma pixel generator assertion macros
// Clocked, reset-gated property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef PLASMA_PIXEL_GENERATOR_MACROS_SVH
`define PLASMA_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ppg_pkg.sv */
// ----------------------------------------------------------------------------
// Plasma pixel generator package
// Field widths, step constants, sine and palette tables, item types.
// ----------------------------------------------------------------------------
package ppg_pkg;

   localparam int ROW_WIDTH           = 5;
   localparam int COLUMN_WIDTH        = 5;
   localparam int SCREEN_COLUMN_WIDTH = 6;
   localparam int COLOR_WIDTH         = 8;
   localparam int PHASE_WIDTH         = 8;
   localparam int OFFSET_WIDTH        = 4;

   localparam int REQ_FIELD_BITS = ROW_WIDTH + COLUMN_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ROW_WIDTH + SCREEN_COLUMN_WIDTH + COLOR_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int MAX_SCREEN_COLUMN = (2 ** COLUMN_WIDTH - 1) + (2 ** OFFSET_WIDTH - 1);

   localparam logic [7:0] XA_FRAME_STEP = 8'hfe;
   localparam logic [7:0] YA_FRAME_STEP = 8'h05;
   localparam logic [7:0] XA_COL_STEP   = 8'h04;
   localparam logic [7:0] YA_ROW_STEP   = 8'h02;
   localparam logic [7:0] XB_COL_STEP   = 8'hfc;
   localparam logic [7:0] YB_ROW_STEP   = 8'hf9;
   localparam logic [7:0] XC_STEP       = 8'h03;
   localparam logic [7:0] YC_STEP       = 8'hfe;
   localparam logic [7:0] WOBBLE_STEP   = 8'hfb;

   localparam logic [7:0] X_DRIFT_STEP_RESET    = 8'd1;
   localparam logic [7:0] Y_DRIFT_STEP_RESET    = 8'd251;
   localparam logic [7:0] X_DRIFT_COUNTER_RESET = 8'd40;
   localparam logic [7:0] Y_DRIFT_COUNTER_RESET = 8'd24;

   localparam logic [7:0] SINE_ROM [256] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
      8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
      8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
      8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
      8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
      8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
      8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
      8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
      8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
      8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
      8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
      8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
      8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
      8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
      8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
      8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
      8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
      8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
      8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
      8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
      8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
      8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
      8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
      8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
      8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
      8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
      8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
      8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
      8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
      8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
   };

   localparam logic [COLOR_WIDTH-1:0] PALETTE [16] = '{
      8'h00, 8'h22, 8'h55, 8'h33, 8'hBB, 8'hAA, 8'hDD, 8'hFF,
      8'hDD, 8'hAA, 8'hBB, 8'h99, 8'h11, 8'h88, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [PHASE_WIDTH-1:0]  x_base_a;
      logic [PHASE_WIDTH-1:0]  x_base_b;
      logic [PHASE_WIDTH-1:0]  y_base_a;
      logic [PHASE_WIDTH-1:0]  y_base_b;
      logic [OFFSET_WIDTH-1:0] offset;
   } frame_params_type;

   typedef struct packed {
      frame_params_type        params;
      logic [ROW_WIDTH-1:0]    row;
      logic [COLUMN_WIDTH-1:0] column;
   } stage_item_type;

   typedef struct packed {
      logic [COLOR_WIDTH-1:0]         color;
      logic [SCREEN_COLUMN_WIDTH-1:0] screen_column;
      logic [ROW_WIDTH-1:0]           screen_row;
   } pixel_type;

endpackage

/* sv/ppg_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// Plasma frame control
// Phase, drift and wobble counters; latches frame bases and offset on a
// frame-start item and supplies the parameters that apply to each item.
// ----------------------------------------------------------------------------
module ppg_frame_ctrl
   import ppg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             frame_start,
   output frame_params_type params
);

   logic [7:0] x_phase_a_ff, x_phase_b_ff, y_phase_a_ff, y_phase_b_ff;
   logic [7:0] x_drift_step_ff, y_drift_step_ff;
   logic [7:0] x_drift_counter_ff, y_drift_counter_ff;
   logic [7:0] wobble_counter_ff;
   logic [7:0] wobble_counter_in;
   frame_params_type params_ff;
   frame_params_type params_in;

   assign wobble_counter_in = wobble_counter_ff + WOBBLE_STEP;

   always_comb begin
      params_in.x_base_a = x_phase_a_ff;
      params_in.x_base_b = x_phase_b_ff;
      params_in.y_base_a = y_phase_a_ff;
      params_in.y_base_b = y_phase_b_ff;
      params_in.offset   = SINE_ROM[wobble_counter_in][7:4];
   end

   assign params = frame_start ? params_in : params_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_phase_a_ff       <= '0;
         x_phase_b_ff       <= '0;
         y_phase_a_ff       <= '0;
         y_phase_b_ff       <= '0;
         x_drift_step_ff    <= X_DRIFT_STEP_RESET;
         y_drift_step_ff    <= Y_DRIFT_STEP_RESET;
         x_drift_counter_ff <= X_DRIFT_COUNTER_RESET;
         y_drift_counter_ff <= Y_DRIFT_COUNTER_RESET;
         wobble_counter_ff  <= '0;
         params_ff          <= '0;
      end else if (accept && frame_start) begin
         x_phase_a_ff       <= x_phase_a_ff + XA_FRAME_STEP;
         x_phase_b_ff       <= x_phase_b_ff + x_drift_step_ff;
         y_phase_a_ff       <= y_phase_a_ff + YA_FRAME_STEP;
         y_phase_b_ff       <= y_phase_b_ff + y_drift_step_ff;
         x_drift_step_ff    <= {4'd0, SINE_ROM[x_drift_counter_ff][7:4]};
         y_drift_step_ff    <= {4'd0, SINE_ROM[y_drift_counter_ff][7:4]};
         x_drift_counter_ff <= x_drift_counter_ff + XC_STEP;
         y_drift_counter_ff <= y_drift_counter_ff + YC_STEP;
         wobble_counter_ff  <= wobble_counter_in;
         params_ff          <= params_in;
      end
   end

endmodule

/* sv/ppg_shade.sv */
// ----------------------------------------------------------------------------
// Plasma shading
// Sums the x and y wave terms from the sine table, picks the palette byte
// and shifts the column by the frame offset.
// ----------------------------------------------------------------------------
module ppg_shade
   import ppg_pkg::*;
(
   input  stage_item_type item,
   output pixel_type      pixel
);

   logic [7:0] column_ext, row_ext;
   logic [7:0] xa_idx, xb_idx, ya_idx, yb_idx;
   logic [7:0] xa_sine, xb_sine, ya_sine, yb_sine;
   logic [7:0] wave_sum;

   always_comb begin
      column_ext = {3'd0, item.column};
      row_ext    = {3'd0, item.row};
      xa_idx = item.params.x_base_a + 8'(XA_COL_STEP * column_ext);
      xb_idx = item.params.x_base_b + 8'(XB_COL_STEP * column_ext);
      ya_idx = item.params.y_base_a + 8'(YA_ROW_STEP * row_ext);
      yb_idx = item.params.y_base_b + 8'(YB_ROW_STEP * row_ext);
      xa_sine = SINE_ROM[xa_idx];
      xb_sine = SINE_ROM[xb_idx];
      ya_sine = SINE_ROM[ya_idx];
      yb_sine = SINE_ROM[yb_idx];
      wave_sum = xa_sine + {1'b0, xb_sine[7:1]} + ya_sine + {2'b0, yb_sine[7:2]};
      pixel.color         = PALETTE[wave_sum[7:4]];
      pixel.screen_column = {1'b0, item.column} + {2'b0, item.params.offset};
      pixel.screen_row    = item.row;
   end

endmodule

/* sv/plasma_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Plasma pixel generator
// One pixel position in, one colored screen pixel out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tuser
//  req_    | in  | row[4:0], column[9:5], zero pad         | frame_start
//  rsp_    | out | screen_row[4:0], screen_column[10:5],   | -
//          |     | color[18:11], zero pad                  |
//
//  One item per cycle unless rsp_ stalls.
//  Input register holds the item with its frame parameters; the sine and
//  palette lookups sit between it and the result register.
//  Synchronous reset restores the phase and drift counters; no clearing pass.
//  A stalled rsp_ side holds its item and fills the input register behind it.
// ----------------------------------------------------------------------------
module plasma_pixel_generator
   import ppg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // row, column
   input  logic                      req_tuser,   // frame_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata    // screen_row, screen_column, color
);

   logic             accept;
   logic             rsp_load;
   logic             stage_valid_ff, stage_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   frame_params_type params;
   stage_item_type   stage_ff;
   pixel_type        pixel;
   pixel_type        rsp_ff;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stage_valid_ff || rsp_load;
   assign accept     = req_tvalid && req_tready;

   ppg_frame_ctrl u_frame_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_tuser),
      .params      (params)
   );

   ppg_shade u_shade (
      .item  (stage_ff),
      .pixel (pixel)
   );

   always_comb begin
      stage_valid_in = accept ? 1'b1 : (rsp_load ? 1'b0 : stage_valid_ff);
      rsp_valid_in   = rsp_load ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.params <= params;
         stage_ff.row    <= req_tdata[ROW_WIDTH-1:0];
         stage_ff.column <= req_tdata[REQ_FIELD_BITS-1:ROW_WIDTH];
      end
      if (rsp_load && stage_valid_ff) begin
         rsp_ff <= pixel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - RSP_FIELD_BITS){1'b0}}, rsp_ff};

endmodule

/* sv/ppg_checker.sv */
// ----------------------------------------------------------------------------
// Plasma pixel generator port checker
// Watches the top-level ports for hold, latency, result range and zero pad.
// ----------------------------------------------------------------------------
`include "plasma_pixel_generator_macros.svh"

module ppg_checker
   import ppg_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   logic req_seen;
   logic rsp_column_ok;
   logic rsp_pad_zero;

   assign req_seen      = req_tvalid && req_tready && (req_tuser || !req_tuser)
                          && (req_tdata == req_tdata);
   assign rsp_column_ok = rsp_tdata[ROW_WIDTH+SCREEN_COLUMN_WIDTH-1:ROW_WIDTH]
                          <= SCREEN_COLUMN_WIDTH'(MAX_SCREEN_COLUMN);
   assign rsp_pad_zero  = rsp_tdata[RSP_DATA_WIDTH-1:RSP_FIELD_BITS] == '0;

   `PPG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp item dropped")
   `PPG_ASSERT_NEXT(a_latency, req_seen ##1 (!rsp_tvalid || rsp_tready), rsp_tvalid, "item late")
   `PPG_ASSERT_NOW(a_column_range, rsp_tvalid, rsp_column_ok, "screen column out of range")
   `PPG_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_pad_zero, "rsp pad bits set")

endmodule

bind plasma_pixel_generator ppg_checker u_ppg_checker (.*);
